>>> src/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg: shell token syntax checker package
// Token kind codes and the neighbor rules shared by the checker.
// ----------------------------------------------------------------------------
package stsc_pkg;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_WORD    = 4'd0;
    localparam kind_t KIND_PIPE    = 4'd1;
    localparam kind_t KIND_AND     = 4'd2;
    localparam kind_t KIND_OR      = 4'd3;
    localparam kind_t KIND_LPAR    = 4'd4;
    localparam kind_t KIND_RPAR    = 4'd5;
    localparam kind_t KIND_IN      = 4'd6;
    localparam kind_t KIND_OUT     = 4'd7;
    localparam kind_t KIND_APPEND  = 4'd8;
    localparam kind_t KIND_HEREDOC = 4'd9;

    function automatic logic is_redir(input kind_t k);
        return (k inside {[KIND_IN:KIND_HEREDOC]});
    endfunction

    function automatic logic is_separator(input kind_t k);
        return (k inside {KIND_PIPE, KIND_AND, KIND_OR});
    endfunction

    function automatic logic is_unknown(input kind_t k);
        return (k > KIND_HEREDOC);
    endfunction

    // allowed kinds for the opening token of a line
    function automatic logic first_ok(input kind_t k);
        return (k == KIND_WORD) || (k == KIND_LPAR) || is_redir(k);
    endfunction

    // may kind n follow kind t
    function automatic logic pair_ok(input kind_t t, input kind_t n);
        logic ok;
        ok = 1'b1;
        if (t == KIND_RPAR) begin
            ok = (n inside {KIND_AND, KIND_OR, KIND_RPAR});
        end else if (is_redir(t)) begin
            ok = (n == KIND_WORD);
        end else if (t == KIND_PIPE) begin
            ok = (n == KIND_WORD) || is_redir(n);
        end else if (t inside {KIND_AND, KIND_OR, KIND_LPAR}) begin
            ok = (n == KIND_WORD) || (n == KIND_LPAR) || is_redir(n);
        end else if (t == KIND_WORD) begin
            ok = (n != KIND_LPAR);
        end
        return ok;
    endfunction

    // may kind k close the line
    function automatic logic end_ok(input kind_t k);
        return !(is_redir(k) || is_separator(k) || (k == KIND_LPAR));
    endfunction

endpackage

>>> src/shell_token_syntax_checker.sv
// ----------------------------------------------------------------------------
// shell_token_syntax_checker
// Streams shell token kinds and gives one valid/invalid verdict per line.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | sink      | in_valid / in_stall | token_kind[3:0], last_token
//  out     | source    | out_valid/out_stall | line_valid
//
//  One token beat per cycle while in_stall is low. Each beat updates the
//  line state in the same cycle; a beat with last_token set loads the
//  verdict into the output register, which is shown on the next cycle,
//  and returns the line state to its reset values. Tokens before the last
//  produce no output beat. in_stall rises only while a verdict waits in the
//  output register and out_stall holds it. Reset is asynchronous, active low,
//  and leaves the block ready for the first token of a line.
//
module shell_token_syntax_checker #(
    parameter int MAX_NESTING = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  stsc_pkg::kind_t   token_kind,
    input  logic              last_token,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              line_valid
);
    import stsc_pkg::*;

    // signed balance wide enough for +-MAX_NESTING
    localparam int BAL_W = $clog2(MAX_NESTING + 1) + 1;
    localparam logic signed [BAL_W-1:0] BAL_MAX  = BAL_W'(MAX_NESTING);
    localparam logic signed [BAL_W-1:0] BAL_MIN  = -BAL_MAX;
    localparam logic signed [BAL_W-1:0] BAL_ONE  = BAL_W'(1);
    localparam logic signed [BAL_W-1:0] BAL_ZERO = '0;

    // line state
    kind_t                    previous_kind_reg;
    logic                     at_first_token_reg;
    logic                     error_seen_reg;
    logic                     skip_target_word_reg;
    logic                     command_seen_reg;
    logic signed [BAL_W-1:0]  paren_balance_reg;

    logic                     error_seen_next;
    logic                     skip_target_word_next;
    logic                     command_seen_next;
    logic signed [BAL_W-1:0]  paren_balance_next;
    logic                     verdict;

    // result register
    logic                     out_valid_reg;
    logic                     line_valid_reg;

    logic                     accept;

    // hold input only when a verdict is parked and the sink is stalling
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        error_seen_next       = error_seen_reg;
        skip_target_word_next = skip_target_word_reg;
        command_seen_next     = command_seen_reg;
        paren_balance_next    = paren_balance_reg;

        if (is_unknown(token_kind))
        begin
            error_seen_next = 1'b1;
        end

        // opening-kind check, or neighbor-pair check
        if (at_first_token_reg)
        begin
            if (!first_ok(token_kind))
            begin
                error_seen_next = 1'b1;
            end
        end
        else if (!pair_ok(previous_kind_reg, token_kind))
        begin
            error_seen_next = 1'b1;
        end

        // a redirection target word is not a command
        if (skip_target_word_reg)
        begin
            skip_target_word_next = 1'b0;
        end
        else if (token_kind == KIND_WORD)
        begin
            command_seen_next = 1'b1;
        end
        else if (is_redir(token_kind))
        begin
            skip_target_word_next = 1'b1;
        end

        // every separator needs a command before it
        if (is_separator(token_kind))
        begin
            if (!command_seen_next)
            begin
                error_seen_next = 1'b1;
            end
            command_seen_next = 1'b0;
        end

        // balance saturates at +-MAX_NESTING and flags the overflow
        if (token_kind == KIND_LPAR)
        begin
            if (paren_balance_reg >= BAL_MAX)
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                paren_balance_next = paren_balance_reg + BAL_ONE;
            end
        end
        else if (token_kind == KIND_RPAR)
        begin
            if (paren_balance_reg <= BAL_MIN)
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                paren_balance_next = paren_balance_reg - BAL_ONE;
            end
        end

        verdict = ~error_seen_next & end_ok(token_kind) & command_seen_next
                  & (paren_balance_next == BAL_ZERO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_kind_reg    <= KIND_WORD;
            at_first_token_reg   <= 1'b1;
            error_seen_reg       <= 1'b0;
            skip_target_word_reg <= 1'b0;
            command_seen_reg     <= 1'b0;
            paren_balance_reg    <= BAL_ZERO;
        end
        else if (accept)
        begin
            if (last_token)
            begin
                // line done: back to the reset state
                previous_kind_reg    <= KIND_WORD;
                at_first_token_reg   <= 1'b1;
                error_seen_reg       <= 1'b0;
                skip_target_word_reg <= 1'b0;
                command_seen_reg     <= 1'b0;
                paren_balance_reg    <= BAL_ZERO;
            end
            else
            begin
                previous_kind_reg    <= token_kind;
                at_first_token_reg   <= 1'b0;
                error_seen_reg       <= error_seen_next;
                skip_target_word_reg <= skip_target_word_next;
                command_seen_reg     <= command_seen_next;
                paren_balance_reg    <= paren_balance_next;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_token)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_token)
        begin
            line_valid_reg <= verdict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_valid = line_valid_reg;

endmodule
